// ===== src/snmp_hdr_pkg.sv =====
// Types and constants for the SNMPv2c header parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package snmp_hdr_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic        valid_res;
    logic [3:0]  fault_code;
    logic [7:0]  pdu_kind;
    logic [31:0] request_ident;
    logic [31:0] message_length;
    logic [31:0] pdu_length_out;
    logic [15:0] name_length;
    logic [15:0] index_length;
    logic        final_res;
  } out_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  field_count;
    logic [31:0] length_accum;
    logic [31:0] seq_len;
    logic [31:0] pdu_len;
    logic [15:0] community_left;
    logic [15:0] name_count;
    logic [15:0] index_count;
    logic        seen_at;
    logic [7:0]  pdu_reg;
    logic [31:0] req_id;
    logic [3:0]  error_reg;
  } st_t;

  localparam logic [3:0] PH_SEQ_TAG   = 4'd0;
  localparam logic [3:0] PH_SEQ_LEN   = 4'd1;
  localparam logic [3:0] PH_SEQ_MORE  = 4'd2;
  localparam logic [3:0] PH_VERSION   = 4'd3;
  localparam logic [3:0] PH_COMM_TAG  = 4'd4;
  localparam logic [3:0] PH_COMM_LEN  = 4'd5;
  localparam logic [3:0] PH_COMM_MORE = 4'd6;
  localparam logic [3:0] PH_COMMUNITY = 4'd7;
  localparam logic [3:0] PH_PDU_TAG   = 4'd8;
  localparam logic [3:0] PH_PDU_LEN   = 4'd9;
  localparam logic [3:0] PH_PDU_MORE  = 4'd10;
  localparam logic [3:0] PH_ID_TAG    = 4'd11;
  localparam logic [3:0] PH_ID_LEN    = 4'd12;
  localparam logic [3:0] PH_ID_BYTES  = 4'd13;
  localparam logic [3:0] PH_DATA      = 4'd14;
  localparam logic [3:0] PH_SKIP      = 4'd15;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_SHORT     = 4'd1;
  localparam logic [3:0] ERR_SEQ_TAG   = 4'd2;
  localparam logic [3:0] ERR_SEQ_WIDE  = 4'd3;
  localparam logic [3:0] ERR_SEQ_ZERO  = 4'd4;
  localparam logic [3:0] ERR_VERSION   = 4'd5;
  localparam logic [3:0] ERR_COMM_TAG  = 4'd6;
  localparam logic [3:0] ERR_COMM_WIDE = 4'd7;
  localparam logic [3:0] ERR_COMM_ZERO = 4'd8;
  localparam logic [3:0] ERR_PDU_TAG   = 4'd9;
  localparam logic [3:0] ERR_PDU_WIDE  = 4'd10;
  localparam logic [3:0] ERR_ID_TAG    = 4'd11;
  localparam logic [3:0] ERR_ID_LEN    = 4'd12;
  localparam logic [3:0] ERR_TRUNC     = 4'd13;

  localparam logic [2:0] KIND_HDR     = 3'd0;
  localparam logic [2:0] KIND_NAME    = 3'd1;
  localparam logic [2:0] KIND_INDEX   = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  localparam logic [7:0] TAG_SEQ   = 8'h30;
  localparam logic [7:0] TAG_INT   = 8'h02;
  localparam logic [7:0] TAG_OCTET = 8'h04;
  localparam logic [7:0] TAG_GET   = 8'ha0;
  localparam logic [7:0] TAG_NEXT  = 8'ha1;
  localparam logic [7:0] TAG_RESP  = 8'ha2;
  localparam logic [7:0] TAG_BULK  = 8'ha5;
  localparam logic [7:0] VER_0     = 8'h02;
  localparam logic [7:0] VER_1     = 8'h01;
  localparam logic [7:0] VER_2     = 8'h01;
  localparam logic [7:0] ID_LEN    = 8'h04;
  localparam logic [7:0] CHAR_AT   = 8'h40;
  localparam int         MIN_BYTES = 7;

  localparam st_t ST_RESET = '{
    phase: PH_SEQ_TAG, field_count: 4'd0, length_accum: 32'd0, seq_len: 32'd0,
    pdu_len: 32'd0, community_left: 16'd0, name_count: 16'd0, index_count: 16'd0,
    seen_at: 1'b0, pdu_reg: 8'd0, req_id: 32'd0, error_reg: ERR_NONE
  };

endpackage

// ===== src/snmp_hdr_step.sv =====
// Per-byte parser update: next header state, byte result and summary result.
// Depends on snmp_hdr_pkg.
`timescale 1ns / 1ps

module snmp_hdr_step #(
  parameter int LEN_BYTES     = 4,
  parameter int MAX_MSG_BYTES = 65536,
  parameter int SEEN_W        = $clog2(MAX_MSG_BYTES + 1)
) (
  input  snmp_hdr_pkg::st_t  st,
  input  logic [SEEN_W-1:0]  bytes_seen,
  input  snmp_hdr_pkg::in_t  item,
  output snmp_hdr_pkg::st_t  st_next,
  output logic [SEEN_W-1:0]  bytes_seen_next,
  output snmp_hdr_pkg::out_t byte_res,
  output snmp_hdr_pkg::out_t sum_res
);

  function automatic snmp_hdr_pkg::st_t fail(snmp_hdr_pkg::st_t s, logic [3:0] code);
    snmp_hdr_pkg::st_t r;
    r = s;
    r.error_reg = code;
    r.phase = snmp_hdr_pkg::PH_SKIP;
    return r;
  endfunction

  function automatic snmp_hdr_pkg::st_t len_done(snmp_hdr_pkg::st_t s, logic [3:0] owner);
    snmp_hdr_pkg::st_t r;
    r = s;
    case (owner)
      snmp_hdr_pkg::PH_SEQ_LEN: begin
        if (s.length_accum == 32'd0) begin
          r = fail(s, snmp_hdr_pkg::ERR_SEQ_ZERO);
        end else begin
          r.seq_len = s.length_accum;
          r.field_count = 4'd0;
          r.phase = snmp_hdr_pkg::PH_VERSION;
        end
      end
      snmp_hdr_pkg::PH_COMM_LEN: begin
        if (s.length_accum == 32'd0) begin
          r = fail(s, snmp_hdr_pkg::ERR_COMM_ZERO);
        end else if (s.length_accum[31:16] != 16'd0) begin
          r = fail(s, snmp_hdr_pkg::ERR_COMM_WIDE);
        end else begin
          r.community_left = s.length_accum[15:0];
          r.phase = snmp_hdr_pkg::PH_COMMUNITY;
        end
      end
      default: begin
        r.pdu_len = s.length_accum;
        r.phase = snmp_hdr_pkg::PH_ID_TAG;
      end
    endcase
    return r;
  endfunction

  function automatic snmp_hdr_pkg::st_t len_first(snmp_hdr_pkg::st_t s, logic [3:0] owner,
                                                  logic [7:0] b, logic [3:0] wide_err);
    snmp_hdr_pkg::st_t r;
    r = s;
    r.length_accum = 32'd0;
    if (!b[7]) begin
      r.length_accum = {24'd0, b};
      r = len_done(r, owner);
    end else if (b[6:0] > 7'(LEN_BYTES)) begin
      r = fail(r, wide_err);
    end else if (b[6:0] == 7'd0) begin
      r = len_done(r, owner);
    end else begin
      r.field_count = b[3:0];
      r.phase = owner + 4'd1;
    end
    return r;
  endfunction

  function automatic snmp_hdr_pkg::st_t len_more(snmp_hdr_pkg::st_t s, logic [3:0] owner,
                                                 logic [7:0] b);
    snmp_hdr_pkg::st_t r;
    r = s;
    r.length_accum = {s.length_accum[23:0], b};
    r.field_count = s.field_count - 4'd1;
    if (r.field_count == 4'd0) begin
      r = len_done(r, owner);
    end
    return r;
  endfunction

  logic [7:0] b;
  logic [7:0] ver_exp;
  logic [2:0] kind;
  logic [3:0] err;

  assign b = item.byte_value;

  always_comb begin
    case (st.field_count[1:0])
      2'd0:    ver_exp = snmp_hdr_pkg::VER_0;
      2'd1:    ver_exp = snmp_hdr_pkg::VER_1;
      default: ver_exp = snmp_hdr_pkg::VER_2;
    endcase
  end

  always_comb begin
    if (bytes_seen < SEEN_W'(MAX_MSG_BYTES)) begin
      bytes_seen_next = bytes_seen + SEEN_W'(1);
    end else begin
      bytes_seen_next = bytes_seen;
    end
  end

  always_comb begin
    st_next = st;
    kind = snmp_hdr_pkg::KIND_HDR;
    case (st.phase)
      snmp_hdr_pkg::PH_SEQ_TAG: begin
        if (b != snmp_hdr_pkg::TAG_SEQ) st_next = fail(st, snmp_hdr_pkg::ERR_SEQ_TAG);
        else st_next.phase = snmp_hdr_pkg::PH_SEQ_LEN;
      end
      snmp_hdr_pkg::PH_SEQ_LEN:
        st_next = len_first(st, snmp_hdr_pkg::PH_SEQ_LEN, b, snmp_hdr_pkg::ERR_SEQ_WIDE);
      snmp_hdr_pkg::PH_SEQ_MORE: st_next = len_more(st, snmp_hdr_pkg::PH_SEQ_LEN, b);
      snmp_hdr_pkg::PH_VERSION: begin
        if (st.field_count > 4'd2 || b != ver_exp) begin
          st_next = fail(st, snmp_hdr_pkg::ERR_VERSION);
        end else if (st.field_count == 4'd2) begin
          st_next.field_count = 4'd0;
          st_next.phase = snmp_hdr_pkg::PH_COMM_TAG;
        end else begin
          st_next.field_count = st.field_count + 4'd1;
        end
      end
      snmp_hdr_pkg::PH_COMM_TAG: begin
        if (b != snmp_hdr_pkg::TAG_OCTET) st_next = fail(st, snmp_hdr_pkg::ERR_COMM_TAG);
        else st_next.phase = snmp_hdr_pkg::PH_COMM_LEN;
      end
      snmp_hdr_pkg::PH_COMM_LEN:
        st_next = len_first(st, snmp_hdr_pkg::PH_COMM_LEN, b, snmp_hdr_pkg::ERR_COMM_WIDE);
      snmp_hdr_pkg::PH_COMM_MORE: st_next = len_more(st, snmp_hdr_pkg::PH_COMM_LEN, b);
      snmp_hdr_pkg::PH_COMMUNITY: begin
        if (st.seen_at || b == snmp_hdr_pkg::CHAR_AT) begin
          st_next.seen_at = 1'b1;
          st_next.index_count = st.index_count + 16'd1;
          kind = snmp_hdr_pkg::KIND_INDEX;
        end else begin
          st_next.name_count = st.name_count + 16'd1;
          kind = snmp_hdr_pkg::KIND_NAME;
        end
        st_next.community_left = st.community_left - 16'd1;
        if (st_next.community_left == 16'd0) st_next.phase = snmp_hdr_pkg::PH_PDU_TAG;
      end
      snmp_hdr_pkg::PH_PDU_TAG: begin
        st_next.pdu_reg = b;
        if (b != snmp_hdr_pkg::TAG_GET && b != snmp_hdr_pkg::TAG_NEXT &&
            b != snmp_hdr_pkg::TAG_RESP && b != snmp_hdr_pkg::TAG_BULK) begin
          st_next = fail(st_next, snmp_hdr_pkg::ERR_PDU_TAG);
        end else begin
          st_next.phase = snmp_hdr_pkg::PH_PDU_LEN;
        end
      end
      snmp_hdr_pkg::PH_PDU_LEN:
        st_next = len_first(st, snmp_hdr_pkg::PH_PDU_LEN, b, snmp_hdr_pkg::ERR_PDU_WIDE);
      snmp_hdr_pkg::PH_PDU_MORE: st_next = len_more(st, snmp_hdr_pkg::PH_PDU_LEN, b);
      snmp_hdr_pkg::PH_ID_TAG: begin
        if (b != snmp_hdr_pkg::TAG_INT) st_next = fail(st, snmp_hdr_pkg::ERR_ID_TAG);
        else st_next.phase = snmp_hdr_pkg::PH_ID_LEN;
      end
      snmp_hdr_pkg::PH_ID_LEN: begin
        if (b != snmp_hdr_pkg::ID_LEN) begin
          st_next = fail(st, snmp_hdr_pkg::ERR_ID_LEN);
        end else begin
          st_next.field_count = 4'd0;
          st_next.phase = snmp_hdr_pkg::PH_ID_BYTES;
        end
      end
      snmp_hdr_pkg::PH_ID_BYTES: begin
        case (st.field_count[1:0])
          2'd0:    st_next.req_id[7:0]   = st.req_id[7:0]   | b;
          2'd1:    st_next.req_id[15:8]  = st.req_id[15:8]  | b;
          2'd2:    st_next.req_id[23:16] = st.req_id[23:16] | b;
          default: st_next.req_id[31:24] = st.req_id[31:24] | b;
        endcase
        st_next.field_count = st.field_count + 4'd1;
        if (st_next.field_count >= 4'd4) begin
          st_next.field_count = 4'd0;
          st_next.phase = snmp_hdr_pkg::PH_DATA;
        end
      end
      default: kind = snmp_hdr_pkg::KIND_DATA;
    endcase
  end

  always_comb begin
    if (bytes_seen_next < SEEN_W'(snmp_hdr_pkg::MIN_BYTES)) err = snmp_hdr_pkg::ERR_SHORT;
    else if (st_next.error_reg != snmp_hdr_pkg::ERR_NONE) err = st_next.error_reg;
    else if (st_next.phase != snmp_hdr_pkg::PH_DATA) err = snmp_hdr_pkg::ERR_TRUNC;
    else err = snmp_hdr_pkg::ERR_NONE;
  end

  always_comb begin
    byte_res = '0;
    byte_res.kind = kind;
    byte_res.byte_out = b;

    sum_res = '0;
    sum_res.kind = snmp_hdr_pkg::KIND_SUMMARY;
    sum_res.valid_res = (err == snmp_hdr_pkg::ERR_NONE);
    sum_res.fault_code = err;
    sum_res.pdu_kind = st_next.pdu_reg;
    sum_res.request_ident = st_next.req_id;
    sum_res.message_length = st_next.seq_len - {16'd0, st_next.index_count};
    sum_res.pdu_length_out = st_next.pdu_len;
    sum_res.name_length = st_next.name_count;
    sum_res.index_length = st_next.index_count;
    sum_res.final_res = 1'b1;
  end

endmodule

// ===== src/snmp_hdr_fifo.sv =====
// Four-entry result queue; takes one or two results per push, drains one per cycle while result_ready is high.
// Depends on snmp_hdr_pkg.
`timescale 1ns / 1ps

module snmp_hdr_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               push_two,
  input  snmp_hdr_pkg::out_t wr_a,
  input  snmp_hdr_pkg::out_t wr_b,
  output logic               room,
  output logic               result_valid,
  input  logic               result_ready,
  output snmp_hdr_pkg::out_t result
);

  snmp_hdr_pkg::out_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;
  logic [2:0] push_n;

  assign result_valid = (count != 3'd0);
  assign result = mem[rd_ptr];
  assign pop = result_valid && result_ready;
  assign room = (count <= 3'd2);
  assign push_n = push ? (push_two ? 3'd2 : 3'd1) : 3'd0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_a;
      if (push_two) mem[wr_ptr + 2'd1] <= wr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n[1:0];
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + push_n - {2'd0, pop};
    end
  end

endmodule

// ===== src/snmp_v2c_header_parser_core.sv =====
// SNMPv2c header parser: one message byte per transaction, classified results out.
// Each byte's result is written on acceptance to a four-entry queue and offered from it.
// Throughput: one byte per cycle; a final byte yields two results, drained one per cycle
// while result_ready is high; bytes are taken while the queue holds two or fewer.
// Reset: rst is synchronous, active high; it clears parser state and the queue.
`timescale 1ns / 1ps

module snmp_v2c_header_parser_core #(
  parameter int LEN_BYTES     = 4,
  parameter int MAX_MSG_BYTES = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  snmp_hdr_pkg::in_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output snmp_hdr_pkg::out_t result
);

  localparam int SEEN_W = $clog2(MAX_MSG_BYTES + 1);

  snmp_hdr_pkg::st_t  st;
  snmp_hdr_pkg::st_t  st_next;
  logic [SEEN_W-1:0]  bytes_seen;
  logic [SEEN_W-1:0]  bytes_seen_next;
  snmp_hdr_pkg::out_t byte_res;
  snmp_hdr_pkg::out_t sum_res;
  logic               accept;

  assign accept = item_valid && item_ready;

  snmp_hdr_step #(
    .LEN_BYTES     (LEN_BYTES),
    .MAX_MSG_BYTES (MAX_MSG_BYTES),
    .SEEN_W        (SEEN_W)
  ) u_step (
    .st              (st),
    .bytes_seen      (bytes_seen),
    .item            (item),
    .st_next         (st_next),
    .bytes_seen_next (bytes_seen_next),
    .byte_res        (byte_res),
    .sum_res         (sum_res)
  );

  snmp_hdr_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_two     (item.last_byte),
    .wr_a         (byte_res),
    .wr_b         (sum_res),
    .room         (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= snmp_hdr_pkg::ST_RESET;
      bytes_seen <= '0;
    end else if (accept) begin
      if (item.last_byte) begin
        st         <= snmp_hdr_pkg::ST_RESET;
        bytes_seen <= '0;
      end else begin
        st         <= st_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

endmodule

// ===== sim/snmp_v2c_header_parser_core_tb.sv =====
// Testbench for snmp_v2c_header_parser_core: byte-level SNMPv2c header checks and summaries.
// Depends on snmp_hdr_pkg and the parser core; self-contained shadow parser predicts results.
`timescale 1ns / 1ps

module snmp_v2c_header_parser_core_tb;
  import snmp_hdr_pkg::*;

  localparam int LEN_BYTES     = 4;
  localparam int MAX_MSG_BYTES = 65536;
  localparam int RANDOM_BYTES  = 1360;
  localparam int TAIL_CYCLES   = 20;

  localparam int LF_SHORT = 0;
  localparam int LF_LONG  = 1;
  localparam int LF_INDEF = 2;
  localparam int LF_WIDE  = 3;

  typedef struct packed {
    logic hold;
    in_t  data;
  } pending_t;

  logic clk          = 1'b0;
  logic rst          = 1'b1;
  logic item_valid   = 1'b0;
  logic item_ready;
  in_t  item         = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;

  pending_t   message_bytes_q[$];
  out_t       parse_results_q[$];
  logic [7:0] msg[$];
  out_t       oldest;
  int         mismatch_count = 0;
  int         burst_left;
  int         gap_left;
  int         stall_left;
  logic [31:0] stall_pattern;

  logic [7:0] version_seq [3] = '{VER_0, VER_1, VER_2};
  logic [7:0] pdu_tags [4]    = '{TAG_GET, TAG_NEXT, TAG_RESP, TAG_BULK};

  // shadow parser state
  logic [3:0]  phase;
  logic [3:0]  field_cnt;
  logic [31:0] len_accum;
  logic [31:0] seq_len;
  logic [31:0] pdu_len;
  logic [15:0] comm_left;
  logic [15:0] name_cnt;
  logic [15:0] index_cnt;
  logic        at_seen;
  logic [7:0]  pdu_tag;
  logic [31:0] req_id;
  logic [16:0] msg_bytes;
  logic [3:0]  err_code;

  snmp_v2c_header_parser_core #(
    .LEN_BYTES     (LEN_BYTES),
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_parser();
    phase     = PH_SEQ_TAG;
    field_cnt = '0;
    len_accum = '0;
    seq_len   = '0;
    pdu_len   = '0;
    comm_left = '0;
    name_cnt  = '0;
    index_cnt = '0;
    at_seen   = 1'b0;
    pdu_tag   = '0;
    req_id    = '0;
    msg_bytes = '0;
    err_code  = ERR_NONE;
  endtask

  task automatic header_error(input logic [3:0] code);
    err_code = code;
    phase    = PH_SKIP;
  endtask

  task automatic close_length(input logic [3:0] owner);
    if (owner == PH_SEQ_LEN) begin
      if (len_accum == 0) header_error(ERR_SEQ_ZERO);
      else begin
        seq_len   = len_accum;
        field_cnt = '0;
        phase     = PH_VERSION;
      end
    end else if (owner == PH_COMM_LEN) begin
      if (len_accum == 0) header_error(ERR_COMM_ZERO);
      else if (len_accum > 32'hFFFF) header_error(ERR_COMM_WIDE);
      else begin
        comm_left = len_accum[15:0];
        phase     = PH_COMMUNITY;
      end
    end else begin
      pdu_len = len_accum;
      phase   = PH_ID_TAG;
    end
  endtask

  task automatic open_length(input logic [3:0] owner, input logic [7:0] b,
                             input logic [3:0] wide_code);
    len_accum = '0;
    if (!b[7]) begin
      len_accum = {24'd0, b};
      close_length(owner);
    end else if (b[6:0] > LEN_BYTES) begin
      header_error(wide_code);
    end else if (b[6:0] == 0) begin
      close_length(owner);
    end else begin
      field_cnt = b[3:0];
      phase     = owner + 4'd1;
    end
  endtask

  task automatic extend_length(input logic [3:0] owner, input logic [7:0] b);
    len_accum = {len_accum[23:0], b};
    field_cnt = field_cnt - 4'd1;
    if (field_cnt == 0) close_length(owner);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    out_t       r;
    logic [3:0] code;
    r          = '0;
    r.kind     = KIND_HDR;
    r.byte_out = b;
    if (msg_bytes < MAX_MSG_BYTES) msg_bytes = msg_bytes + 17'd1;
    case (phase)
      PH_SEQ_TAG: begin
        if (b != TAG_SEQ) header_error(ERR_SEQ_TAG);
        else phase = PH_SEQ_LEN;
      end
      PH_SEQ_LEN:  open_length(PH_SEQ_LEN, b, ERR_SEQ_WIDE);
      PH_SEQ_MORE: extend_length(PH_SEQ_LEN, b);
      PH_VERSION: begin
        if (field_cnt > 2 || b != version_seq[field_cnt]) header_error(ERR_VERSION);
        else begin
          field_cnt = field_cnt + 4'd1;
          if (field_cnt == 3) begin
            field_cnt = '0;
            phase     = PH_COMM_TAG;
          end
        end
      end
      PH_COMM_TAG: begin
        if (b != TAG_OCTET) header_error(ERR_COMM_TAG);
        else phase = PH_COMM_LEN;
      end
      PH_COMM_LEN:  open_length(PH_COMM_LEN, b, ERR_COMM_WIDE);
      PH_COMM_MORE: extend_length(PH_COMM_LEN, b);
      PH_COMMUNITY: begin
        if (at_seen || b == CHAR_AT) begin
          at_seen   = 1'b1;
          index_cnt = index_cnt + 16'd1;
          r.kind    = KIND_INDEX;
        end else begin
          name_cnt = name_cnt + 16'd1;
          r.kind   = KIND_NAME;
        end
        comm_left = comm_left - 16'd1;
        if (comm_left == 0) phase = PH_PDU_TAG;
      end
      PH_PDU_TAG: begin
        pdu_tag = b;
        if (b == TAG_GET || b == TAG_NEXT || b == TAG_RESP || b == TAG_BULK)
          phase = PH_PDU_LEN;
        else
          header_error(ERR_PDU_TAG);
      end
      PH_PDU_LEN:  open_length(PH_PDU_LEN, b, ERR_PDU_WIDE);
      PH_PDU_MORE: extend_length(PH_PDU_LEN, b);
      PH_ID_TAG: begin
        if (b != TAG_INT) header_error(ERR_ID_TAG);
        else phase = PH_ID_LEN;
      end
      PH_ID_LEN: begin
        if (b != ID_LEN) header_error(ERR_ID_LEN);
        else begin
          field_cnt = '0;
          phase     = PH_ID_BYTES;
        end
      end
      PH_ID_BYTES: begin
        req_id    = req_id | ({24'd0, b} << (8 * field_cnt[1:0]));
        field_cnt = field_cnt + 4'd1;
        if (field_cnt >= 4) begin
          field_cnt = '0;
          phase     = PH_DATA;
        end
      end
      default: r.kind = KIND_DATA;
    endcase
    parse_results_q.push_back(r);
    if (last) begin
      if (msg_bytes < MIN_BYTES) code = ERR_SHORT;
      else if (err_code != ERR_NONE) code = err_code;
      else if (phase != PH_DATA) code = ERR_TRUNC;
      else code = ERR_NONE;
      r                = '0;
      r.kind           = KIND_SUMMARY;
      r.valid_res      = (code == ERR_NONE);
      r.fault_code     = code;
      r.pdu_kind       = pdu_tag;
      r.request_ident  = req_id;
      r.message_length = seq_len - {16'd0, index_cnt};
      r.pdu_length_out = pdu_len;
      r.name_length    = name_cnt;
      r.index_length   = index_cnt;
      r.final_res      = 1'b1;
      parse_results_q.push_back(r);
      clear_parser();
    end
  endtask

  function automatic string describe(input out_t r);
    return $sformatf({"kind=%0d byte=%h ok=%b err=%0d pdu=%h id=%h mlen=%h plen=%h",
                      " nm=%0d ix=%0d f=%b"},
                     r.kind, r.byte_out, r.valid_res, r.fault_code, r.pdu_kind,
                     r.request_ident, r.message_length, r.pdu_length_out,
                     r.name_length, r.index_length, r.final_res);
  endfunction

  function automatic int pick_form();
    int c;
    c = $urandom_range(0, 39);
    if (c == 0) return LF_WIDE;
    if (c == 1) return LF_INDEF;
    return (c % 2) ? LF_SHORT : LF_LONG;
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2:    return $urandom;
      3:       return $urandom_range(128, 70000);
      default: return $urandom_range(1, 127);
    endcase
  endfunction

  task automatic push_length(input logic [31:0] value, input int form,
                             output logic [31:0] decoded);
    int n;
    int nmin;
    decoded = value;
    nmin = value[31:24] != 0 ? 4 : value[23:16] != 0 ? 3 : value[15:8] != 0 ? 2 : 1;
    if (form == LF_INDEF) begin
      msg.push_back(8'h80);
      decoded = '0;
    end else if (form == LF_WIDE) begin
      msg.push_back(8'h80 | 8'($urandom_range(LEN_BYTES + 1, 127)));
      decoded = '0;
    end else if (form == LF_SHORT && value < 128) begin
      msg.push_back(value[7:0]);
    end else begin
      n = $urandom_range(nmin, LEN_BYTES);
      msg.push_back(8'h80 | 8'(n));
      for (int i = n - 1; i >= 0; i--) msg.push_back(value[8*i +: 8]);
    end
  endtask

  task automatic enqueue_message(input bit hold);
    pending_t p;
    foreach (msg[i]) begin
      p.hold            = hold && (i == 0);
      p.data.byte_value = msg[i];
      p.data.last_byte  = (i == msg.size() - 1);
      message_bytes_q.push_back(p);
    end
  endtask

  // mostly well-formed headers; some with one corrupted header byte, some cut short, some noise
  task automatic build_message(input bit hold);
    int          style;
    int          hdr_end;
    int          at_pos;
    int          keep;
    logic [31:0] comm_len;
    logic [31:0] decoded;
    msg.delete();
    style = $urandom_range(0, 99);
    if (style < 8) begin
      repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom));
    end else begin
      msg.push_back(TAG_SEQ);
      push_length(pick_length(), pick_form(), decoded);
      for (int i = 0; i < 3; i++) msg.push_back(version_seq[i]);
      msg.push_back(TAG_OCTET);
      case ($urandom_range(0, 29))
        0:       comm_len = 32'd0;
        1:       comm_len = $urandom_range(32'h10000, 32'hFFFFFFFF);
        2:       comm_len = $urandom_range(100, 400);
        default: comm_len = $urandom_range(1, 10);
      endcase
      push_length(comm_len, pick_form(), decoded);
      if (decoded <= 32'hFFFF) begin
        at_pos = $urandom_range(0, 1) ? int'($urandom_range(0, decoded)) : -1;
        for (int i = 0; i < decoded; i++)
          msg.push_back(i == at_pos ? CHAR_AT : 8'($urandom));
      end
      msg.push_back($urandom_range(0, 9) == 0 ? 8'($urandom) : pdu_tags[$urandom_range(0, 3)]);
      push_length(pick_length(), pick_form(), decoded);
      msg.push_back(TAG_INT);
      msg.push_back(ID_LEN);
      repeat (4) msg.push_back(8'($urandom));
      hdr_end = msg.size();
      repeat ($urandom_range(0, 4)) msg.push_back(8'($urandom));
      if (style < 30) begin
        msg[$urandom_range(0, hdr_end - 1)] = 8'($urandom);
      end else if (style < 45) begin
        keep = $urandom_range(1, msg.size());
        while (msg.size() > keep) void'(msg.pop_back());
      end
    end
    enqueue_message(hold);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!item_valid || item_ready) begin
      if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        item_valid <= 1'b0;
      end else if (message_bytes_q.size() != 0 &&
                   !(message_bytes_q[0].hold && (item_valid || parse_results_q.size() != 0))) begin
        item       <= message_bytes_q.pop_front().data;
        item_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, reloaded from time to time
  always @(posedge clk) begin
    if (rst) begin
      result_ready  <= 1'b0;
      stall_pattern <= '1;
      stall_left    <= 0;
    end else begin
      if (stall_left == 0) begin
        stall_left <= $urandom_range(16, 200);
        case ($urandom_range(0, 2))
          0:       stall_pattern <= '1;
          1:       stall_pattern <= $urandom | 32'h11111111;
          default: stall_pattern <= ($urandom & $urandom) | 32'h00010001;
        endcase
      end else begin
        stall_left    <= stall_left - 1;
        stall_pattern <= {stall_pattern[0], stall_pattern[31:1]};
      end
      result_ready <= stall_pattern[0];
    end
  end

  // check results first, then predict from the byte taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (parse_results_q.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result: %s", describe(result));
          mismatch_count++;
        end else begin
          oldest = parse_results_q.pop_front();
          if (result !== oldest) begin
            if (mismatch_count < 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  exp %s", describe(oldest));
              $display("  got %s", describe(result));
            end
            mismatch_count++;
          end
        end
      end
      if (item_valid && item_ready) parse_byte(item.byte_value, item.last_byte);
    end
  end

  initial begin
    int random_start;
    bit first;
    clear_parser();

    // valid get, community with index marker, request ID extremes, trailing data
    msg = '{TAG_SEQ, 8'h1a, VER_0, VER_1, VER_2, TAG_OCTET, 8'h04, 8'h61, CHAR_AT, 8'h62,
            CHAR_AT, TAG_GET, 8'h0c, TAG_INT, ID_LEN, 8'hff, 8'h00, 8'h80, 8'h7f, 8'h00,
            8'hff};
    enqueue_message(1'b0);
    // short message wins over truncation
    msg = '{TAG_SEQ, 8'h05, VER_0, VER_1, VER_2, TAG_OCTET};
    enqueue_message(1'b0);
    msg = '{8'h31, TAG_SEQ, 8'h05, VER_0, VER_1, VER_2, TAG_OCTET, 8'h00};
    enqueue_message(1'b0);
    // indefinite sequence length decodes as zero
    msg = '{TAG_SEQ, 8'h80, VER_0, VER_1, VER_2, TAG_OCTET, 8'h01, 8'h41};
    enqueue_message(1'b0);
    msg = '{TAG_SEQ, 8'h85, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, VER_0};
    enqueue_message(1'b0);
    // widest sequence length, indefinite PDU length, ends right after the request ID
    msg = '{TAG_SEQ, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff, VER_0, VER_1, VER_2, TAG_OCTET,
            8'h81, 8'h02, 8'h78, CHAR_AT, TAG_BULK, 8'h80, TAG_INT, ID_LEN, 8'h01, 8'h02,
            8'h03, 8'h04};
    enqueue_message(1'b0);
    // ends inside the community; index length exceeds sequence length
    msg = '{TAG_SEQ, 8'h01, VER_0, VER_1, VER_2, TAG_OCTET, 8'h05, CHAR_AT, 8'h61};
    enqueue_message(1'b0);
    msg = '{TAG_SEQ, 8'h10, VER_0, VER_1, VER_2, TAG_OCTET, 8'h01, 8'h63, TAG_NEXT, 8'h82,
            8'h01, 8'h00, TAG_INT, 8'h03, 8'h00};
    enqueue_message(1'b0);

    random_start = message_bytes_q.size();
    first        = 1'b1;
    while (message_bytes_q.size() - random_start < RANDOM_BYTES) begin
      build_message(first || $urandom_range(0, 24) == 0);
      first = 1'b0;
    end

    // two-byte community length, long trailing data after the request ID
    msg = '{TAG_SEQ, 8'h84, 8'h00, 8'h00, 8'h01, 8'h20, VER_0, VER_1, VER_2, TAG_OCTET,
            8'h82, 8'h01, 8'h00};
    for (int i = 0; i < 256; i++) msg.push_back(i == 200 ? CHAR_AT : 8'($urandom));
    msg.push_back(TAG_RESP);
    msg.push_back(8'h81);
    msg.push_back(8'h20);
    msg.push_back(TAG_INT);
    msg.push_back(ID_LEN);
    repeat (14) msg.push_back(8'($urandom));
    enqueue_message(1'b1);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (message_bytes_q.size() != 0 || item_valid || parse_results_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("snmp_v2c_header_parser_core verification clean");
    else
      $display("snmp_v2c_header_parser_core verification failed");
    $finish;
  end

  initial begin
    #80000000;
    $display("snmp_v2c_header_parser_core verification failed");
    $finish;
  end

endmodule
